### sv/uctsq_pkg.sv
// ----------------------------------------------------------------------------
// uctsq_pkg: shared types and constants
// Codes, phase encoding and transaction payloads of the control transfer
// sequencer.
// ----------------------------------------------------------------------------
package uctsq_pkg;

    localparam int ADDR_WIDTH   = 32;
    localparam int BUF_ADDR_W   = 32;
    localparam int LEN_W        = 16;
    localparam int SIZE_W       = 7;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_IDX_W    = 1;

    localparam logic [SIZE_W-1:0] EP0_MAX_SIZE = SIZE_W'(64);
    localparam logic [SIZE_W-1:0] EP0_MIN_SIZE = SIZE_W'(8);

    typedef enum logic [1:0] {
        ACT_START     = 2'd0,
        ACT_XFER_DONE = 2'd1,
        ACT_BUS_RESET = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_PACKET_SIZE   = 1'd0,
        CFG_RX_BUFFER_ADDRESS = 1'd1
    } t_cfg_index;

    typedef enum logic [4:0] {
        PH_IDLE       = 5'b00001,
        PH_DATA_TX    = 5'b00010,
        PH_DATA_RX    = 5'b00100,
        PH_STATUS_IN  = 5'b01000,
        PH_STATUS_OUT = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [1:0]            action;
        logic                  host_writes;
        logic [BUF_ADDR_W-1:0] buffer_address;
        logic [LEN_W-1:0]      length;
        logic                  in_token;
        logic                  has_callback;
    } t_req;

    typedef struct packed {
        logic                  arm_valid;
        logic                  arm_in;
        logic [BUF_ADDR_W-1:0] arm_address;
        logic [SIZE_W-1:0]     arm_size;
        logic                  arm_toggle;
        logic                  completed;
        logic                  active;
    } t_rsp;

    typedef struct packed {
        logic [SIZE_W-1:0]     max_packet_size;
        logic [BUF_ADDR_W-1:0] rx_buffer_address;
    } t_cfg;

endpackage

### sv/uctsq_req_if.sv
// ----------------------------------------------------------------------------
// uctsq_req_if: request channel
// Valid/ready channel carrying one sequencer event per transaction.
// ----------------------------------------------------------------------------
interface uctsq_req_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      action;
    logic                            host_writes;
    logic [uctsq_pkg::BUF_ADDR_W-1:0] buffer_address;
    logic [uctsq_pkg::LEN_W-1:0]     length;
    logic                            in_token;
    logic                            has_callback;

    modport source (
        output valid, action, host_writes, buffer_address, length, in_token,
               has_callback,
        input  ready
    );
    modport sink (
        input  valid, action, host_writes, buffer_address, length, in_token,
               has_callback,
        output ready
    );
endinterface

### sv/uctsq_rsp_if.sv
// ----------------------------------------------------------------------------
// uctsq_rsp_if: result channel
// Valid/ready channel carrying one arm/complete result per transaction.
// ----------------------------------------------------------------------------
interface uctsq_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             arm_valid;
    logic                             arm_in;
    logic [uctsq_pkg::BUF_ADDR_W-1:0] arm_address;
    logic [uctsq_pkg::SIZE_W-1:0]     arm_size;
    logic                             arm_toggle;
    logic                             completed;
    logic                             active;

    modport source (
        output valid, arm_valid, arm_in, arm_address, arm_size, arm_toggle,
               completed, active,
        input  ready
    );
    modport sink (
        input  valid, arm_valid, arm_in, arm_address, arm_size, arm_toggle,
               completed, active,
        output ready
    );
endinterface

### sv/usb_control_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// usb_control_transfer_sequencer: endpoint zero control transfer sequencer
// Input register, stage machine with combinational next-state logic, and result register.
// ----------------------------------------------------------------------------
// Takes one event per clock while not stalled and returns exactly one result
// for each. An accepted event is held in the input register and, once the
// result register is free or being taken, passes through the stage machine
// into the result register, from which it is presented. The stage machine
// state updates in the same cycle an event leaves the input register, so
// consecutive events see each other's effect without gaps. A full result
// register that is not taken stalls the input side. Configuration writes take
// effect on the next clock and are to be made while no event is in flight.
module usb_control_transfer_sequencer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [uctsq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [uctsq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    uctsq_req_if.sink                        i_req,
    uctsq_rsp_if.source                      o_rsp
);
    import uctsq_pkg::*;

    logic r_in_valid;
    t_req r_in;
    logic r_out_valid;
    t_rsp r_out;
    logic w_step;
    t_req w_req;
    t_rsp w_rsp;
    t_cfg w_cfg;

    assign w_req.action         = i_req.action;
    assign w_req.host_writes    = i_req.host_writes;
    assign w_req.buffer_address = i_req.buffer_address;
    assign w_req.length         = i_req.length;
    assign w_req.in_token       = i_req.in_token;
    assign w_req.has_callback   = i_req.has_callback;

    assign w_step      = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_step;

    uctsq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    uctsq_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_req   (r_in),
        .i_cfg   (w_cfg),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= w_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_rsp;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.arm_valid   = r_out.arm_valid;
    assign o_rsp.arm_in      = r_out.arm_in;
    assign o_rsp.arm_address = r_out.arm_address;
    assign o_rsp.arm_size    = r_out.arm_size;
    assign o_rsp.arm_toggle  = r_out.arm_toggle;
    assign o_rsp.completed   = r_out.completed;
    assign o_rsp.active      = r_out.active;

endmodule

### sv/uctsq_cfg.sv
// ----------------------------------------------------------------------------
// uctsq_cfg: configuration registers
// Holds the packet size (clamped to the legal range on write) and the setup
// receive buffer address.
// ----------------------------------------------------------------------------
module uctsq_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [uctsq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [uctsq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output uctsq_pkg::t_cfg                  o_cfg
);
    import uctsq_pkg::*;

    logic [SIZE_W-1:0]     r_mps;
    logic [BUF_ADDR_W-1:0] r_rx_addr;
    logic [SIZE_W-1:0]     w_raw;
    logic [SIZE_W-1:0]     w_clamped;

    assign w_raw = i_cfg_data[SIZE_W-1:0];

    always_comb begin
        if (w_raw < EP0_MIN_SIZE) begin
            w_clamped = EP0_MIN_SIZE;
        end else if (w_raw > EP0_MAX_SIZE) begin
            w_clamped = EP0_MAX_SIZE;
        end else begin
            w_clamped = w_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mps     <= EP0_MAX_SIZE;
            r_rx_addr <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_MAX_PACKET_SIZE:   r_mps     <= w_clamped;
                CFG_RX_BUFFER_ADDRESS: r_rx_addr <= i_cfg_data[BUF_ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.max_packet_size   = r_mps;
    assign o_cfg.rx_buffer_address = r_rx_addr;

endmodule

### sv/uctsq_core.sv
// ----------------------------------------------------------------------------
// uctsq_core: stage machine
// Phase, address, remaining count, toggle and callback state, with the
// combinational next-state and result logic for one event.
// ----------------------------------------------------------------------------
module uctsq_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  uctsq_pkg::t_req i_req,
    input  uctsq_pkg::t_cfg i_cfg,
    output uctsq_pkg::t_rsp o_rsp
);
    import uctsq_pkg::*;

    t_phase                r_phase,    n_phase;
    logic [ADDR_WIDTH-1:0] r_addr,     n_addr;
    logic [LEN_W-1:0]      r_rem,      n_rem;
    logic                  r_tog,      n_tog;
    logic                  r_cb,       n_cb;

    t_phase                w_phase;
    logic [ADDR_WIDTH-1:0] w_addr;
    logic [LEN_W-1:0]      w_rem;
    logic                  w_tog;
    logic                  w_cb;
    logic                  w_tok;
    logic                  w_busy;
    logic                  w_advance;
    logic [SIZE_W-1:0]     w_size;
    logic                  w_dir_in;
    t_rsp                  w_rsp;

    assign w_busy = (r_phase != PH_IDLE);

    always_comb begin
        w_phase   = r_phase;
        w_addr    = r_addr;
        w_rem     = r_rem;
        w_tog     = r_tog;
        w_cb      = r_cb;
        w_tok     = i_req.in_token;
        w_advance = 1'b0;
        w_rsp     = '0;
        w_rsp.active = w_busy;
        case (t_action'(i_req.action))
            ACT_START: begin
                w_phase      = i_req.host_writes ? PH_DATA_RX : PH_DATA_TX;
                w_addr       = ADDR_WIDTH'(i_req.buffer_address);
                w_rem        = i_req.length;
                w_tog        = 1'b1;
                w_cb         = i_req.has_callback;
                w_tok        = !i_req.host_writes;
                w_advance    = 1'b1;
                w_rsp.active = 1'b1;
            end
            ACT_XFER_DONE: begin
                w_advance = w_busy;
            end
            ACT_BUS_RESET: begin
                w_phase = PH_IDLE;
                w_cb    = 1'b0;
            end
            default: ;
        endcase
    end

    assign w_dir_in = (w_phase == PH_DATA_TX);
    assign w_size   = (w_rem > LEN_W'(i_cfg.max_packet_size)) ?
                      i_cfg.max_packet_size : w_rem[SIZE_W-1:0];

    always_comb begin
        n_phase = w_phase;
        n_addr  = w_addr;
        n_rem   = w_rem;
        n_tog   = w_tog;
        n_cb    = w_cb;
        o_rsp   = w_rsp;
        if (w_advance) begin
            if (w_phase == PH_DATA_TX || w_phase == PH_DATA_RX) begin
                o_rsp.arm_valid = 1'b1;
                if (w_rem != '0) begin
                    o_rsp.arm_in      = w_dir_in;
                    o_rsp.arm_address = BUF_ADDR_W'(w_addr);
                    o_rsp.arm_size    = w_size;
                    o_rsp.arm_toggle  = w_tog;
                    n_addr = w_addr + ADDR_WIDTH'(w_size);
                    n_rem  = w_rem - LEN_W'(w_size);
                    n_tog  = !w_tog;
                end else begin
                    n_phase          = w_dir_in ? PH_STATUS_OUT : PH_STATUS_IN;
                    o_rsp.arm_in     = !w_dir_in;
                    o_rsp.arm_toggle = 1'b1;
                end
            end else if ((w_phase == PH_STATUS_IN && w_tok) ||
                         (w_phase == PH_STATUS_OUT && !w_tok)) begin
                n_phase           = PH_IDLE;
                o_rsp.arm_valid   = 1'b1;
                o_rsp.arm_address = BUF_ADDR_W'(ADDR_WIDTH'(i_cfg.rx_buffer_address));
                o_rsp.arm_size    = i_cfg.max_packet_size;
                o_rsp.completed   = w_cb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_addr  <= '0;
            r_rem   <= '0;
            r_tog   <= 1'b0;
            r_cb    <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_addr  <= n_addr;
            r_rem   <= n_rem;
            r_tog   <= n_tog;
            r_cb    <= n_cb;
        end
    end

endmodule
